// File: sv/adc_millivolt_ascii_formatter_defines.svh
// ----------------------------------------------------------------------------
// ADC millivolt formatter assertion macros
// Shared property forms for the checks at the end of the formatter top level.
// ----------------------------------------------------------------------------
`ifndef ADC_MILLIVOLT_ASCII_FORMATTER_DEFINES_SVH
`define ADC_MILLIVOLT_ASCII_FORMATTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("formatter check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define AMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("formatter check failed: next-cycle rule");

`endif

// File: sv/adc_mv_pkg.sv
// ----------------------------------------------------------------------------
// ADC millivolt formatter package
// Resolution modes, full-scale constants, reciprocals and digit constants.
// ----------------------------------------------------------------------------
package adc_mv_pkg;

  // Sample resolution selected by the configuration register.
  typedef enum logic [1:0] {
    MODE_6B  = 2'd0,
    MODE_8B  = 2'd1,
    MODE_10B = 2'd2,
    MODE_12B = 2'd3
  } mode_t;

  // Register index decode (address bit 2 selects the register word).
  localparam logic REG_RESOLUTION_MODE = 1'b0;

  localparam logic [11:0] MV_FULL_SCALE   = 12'd3300;
  localparam logic [5:0]  DIGIT_CHAR_BASE = 6'h30;

  // Reciprocals of the full-scale counts, scaled by 2^RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 25;
  localparam logic [19:0] RECIP_6B  = 20'((64'd1 << RECIP_SHIFT) / 64'd63);
  localparam logic [19:0] RECIP_8B  = 20'((64'd1 << RECIP_SHIFT) / 64'd255);
  localparam logic [19:0] RECIP_10B = 20'((64'd1 << RECIP_SHIFT) / 64'd1023);
  localparam logic [19:0] RECIP_12B = 20'((64'd1 << RECIP_SHIFT) / 64'd4095);

  // Exact reciprocals for decimal digit extraction of values up to 3300.
  localparam int unsigned DIV1000_SHIFT = 23;
  localparam logic [13:0] DIV1000_MUL   = 14'd8389;
  localparam int unsigned DIV100_SHIFT  = 19;
  localparam logic [13:0] DIV100_MUL    = 14'd5243;
  localparam int unsigned DIV10_SHIFT   = 15;
  localparam logic [13:0] DIV10_MUL     = 14'd3277;

  // Full-scale count for a mode.
  function automatic logic [11:0] full_scale(input mode_t mode);
    logic [11:0] fs;
    unique case (mode)
      MODE_6B:  fs = 12'd63;
      MODE_8B:  fs = 12'd255;
      MODE_10B: fs = 12'd1023;
      MODE_12B: fs = 12'd4095;
      default:  fs = 12'd4095;
    endcase
    return fs;
  endfunction

  // Reciprocal of the full-scale count for a mode.
  function automatic logic [19:0] full_scale_recip(input mode_t mode);
    logic [19:0] m;
    unique case (mode)
      MODE_6B:  m = RECIP_6B;
      MODE_8B:  m = RECIP_8B;
      MODE_10B: m = RECIP_10B;
      MODE_12B: m = RECIP_12B;
      default:  m = RECIP_12B;
    endcase
    return m;
  endfunction

  // q * (2^n - 1) as a shift and subtract, n set by the mode.
  function automatic logic [24:0] times_full_scale(input mode_t mode,
                                                   input logic [11:0] q);
    logic [24:0] qw;
    logic [24:0] sh;
    qw = {13'b0, q};
    unique case (mode)
      MODE_6B:  sh = qw << 6;
      MODE_8B:  sh = qw << 8;
      MODE_10B: sh = qw << 10;
      MODE_12B: sh = qw << 12;
      default:  sh = qw << 12;
    endcase
    return sh - qw;
  endfunction

endpackage

// File: sv/adc_millivolt_ascii_formatter.sv
// ----------------------------------------------------------------------------
// ADC millivolt ASCII formatter
// Scales raw converter counts to millivolts and four ASCII decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one raw sample per word. The out_ channel returns
//   one word per sample: millivolts plus the digits of d.ddd volts, and the
//   over-range flag in out_tuser. A sample above the full-scale count of the
//   configured resolution saturates to 3300 mV with the flag set.
//   The cfg_ port holds the resolution mode register at byte address 0.
// Pipeline:
//   Five register stages: the sample is registered in stage 1 and the result
//   is presented from the stage 5 register. One word is accepted per cycle
//   unless back-pressure has filled every stage; each stage holds at most one
//   word and the slowest stage is the reciprocal multiply.
// Reset:
//   rst_n clears all stage valid bits and sets the resolution to 6 bits.
// Backpressure:
//   When out_tready is low the output word holds. Earlier stages keep filling
//   empty slots, and in_tready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
`include "adc_millivolt_ascii_formatter_defines.svh"

module adc_millivolt_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] raw_sample, [15:12] zero
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [11:0] millivolts, [17:12] volts_char,
                                    // [23:18] tenths_char,
                                    // [29:24] hundredths_char,
                                    // [35:30] thousandths_char, [39:36] zero
  output logic        out_tuser,    // [0] over_range
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import adc_mv_pkg::*;

  // Configuration register.
  mode_t mode_r;
  logic  cfg_wr_en;

  assign cfg_pready = 1'b1;
  assign cfg_wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_RESOLUTION_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_6B;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_pwdata[1:0]);
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_RESOLUTION_MODE) begin
      cfg_prdata = {30'b0, mode_r};
    end else begin
      cfg_prdata = 32'b0;
    end
  end

  // Stage valid bits and the ready chain from the output back.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: product sample * 3300 and the over-range compare.
  logic [11:0] sample;
  logic [23:0] p1_nxt, p1_r;
  logic        over1_nxt, over1_r;
  mode_t       mode1_r;

  assign sample    = in_tdata[11:0];
  assign p1_nxt    = {12'b0, sample} * {12'b0, MV_FULL_SCALE};
  assign over1_nxt = sample > full_scale(mode_r);

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      p1_r    <= p1_nxt;
      over1_r <= over1_nxt;
      mode1_r <= mode_r;
    end
  end

  // Stage 2: quotient estimate by the full-scale reciprocal.
  logic [43:0] recip_prod;
  logic [11:0] q0_nxt, q0_r;
  logic [23:0] p2_r;
  logic        over2_r;
  mode_t       mode2_r;

  assign recip_prod = {20'b0, p1_r} * {24'b0, full_scale_recip(mode1_r)};
  assign q0_nxt     = recip_prod[RECIP_SHIFT +: 12];

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      q0_r    <= q0_nxt;
      p2_r    <= p1_r;
      over2_r <= over1_r;
      mode2_r <= mode1_r;
    end
  end

  // Stage 3: remainder correction and saturation.
  logic [24:0] rem3;
  logic [11:0] mv3_nxt, mv3_r;
  logic        over3_r;

  assign rem3 = {1'b0, p2_r} - times_full_scale(mode2_r, q0_r);

  always_comb begin
    if (over2_r) begin
      mv3_nxt = MV_FULL_SCALE;
    end else if (rem3 >= {13'b0, full_scale(mode2_r)}) begin
      mv3_nxt = q0_r + 12'd1;
    end else begin
      mv3_nxt = q0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      mv3_r   <= mv3_nxt;
      over3_r <= over2_r;
    end
  end

  // Stage 4: quotients by 1000, 100 and 10 in parallel.
  logic [25:0] prod1000, prod100, prod10;
  logic [1:0]  q1000_r;
  logic [5:0]  q100_r;
  logic [8:0]  q10_r;
  logic [11:0] mv4_r;
  logic        over4_r;

  assign prod1000 = {14'b0, mv3_r} * {12'b0, DIV1000_MUL};
  assign prod100  = {14'b0, mv3_r} * {12'b0, DIV100_MUL};
  assign prod10   = {14'b0, mv3_r} * {12'b0, DIV10_MUL};

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      q1000_r <= prod1000[DIV1000_SHIFT +: 2];
      q100_r  <= prod100[DIV100_SHIFT +: 6];
      q10_r   <= prod10[DIV10_SHIFT +: 9];
      mv4_r   <= mv3_r;
      over4_r <= over3_r;
    end
  end

  // Stage 5: digits as differences of neighboring quotients, output word.
  logic [5:0]  dig_tenths, dig_hund;
  logic [5:0]  dig_thou;
  logic [35:0] word_nxt;
  logic [35:0] word_r;
  logic        over5_r;

  assign dig_tenths = q100_r - {1'b0, q1000_r, 3'b0} - {3'b0, q1000_r, 1'b0};
  assign dig_hund   = 6'(q10_r - {q100_r, 3'b0} - {2'b0, q100_r, 1'b0});
  assign dig_thou   = 6'(mv4_r - {q10_r, 3'b0} - {2'b0, q10_r, 1'b0});

  assign word_nxt = {DIGIT_CHAR_BASE + dig_thou,
                     DIGIT_CHAR_BASE + dig_hund,
                     DIGIT_CHAR_BASE + dig_tenths,
                     DIGIT_CHAR_BASE + {4'b0, q1000_r},
                     mv4_r};

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      word_r  <= word_nxt;
      over5_r <= over4_r;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {4'b0, word_r};
  assign out_tuser  = over5_r;

  // Checks on the datapath and the pipeline control.
  `AMF_ASSERT_NOW(a_sat_value, clk, rst_n, out_tvalid && out_tuser,
    out_tdata[11:0] == MV_FULL_SCALE)
  `AMF_ASSERT_NOW(a_mv_range, clk, rst_n, out_tvalid,
    out_tdata[11:0] <= MV_FULL_SCALE && out_tdata[17:12] >= 6'd48 &&
    out_tdata[17:12] <= 6'd51)
  `AMF_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_tvalid && in_tready, v1_r)

endmodule
